// ===== rtl/core/att_pkg.sv =====
// Shared types and constants for the allocation tracking table.
// Used by att_cell, att_ctrl, allocation_tracking_table and att_checker.
package att_pkg;

  localparam int HANDLE_W = 32;
  localparam int SIZE_W   = 24;
  localparam int STAMP_W  = 48;
  localparam int WORD_W   = 32;
  localparam int THR_W    = 43;   // (2^32) * 1000 fits in 43 bits
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 7;
  localparam int COUNT_W  = 8;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 216;
  localparam int CFG_IDX_W  = 1;

  localparam int US_PER_MS = 1000;
  localparam logic [WORD_W-1:0] LEAK_AGE_RESET = 32'd30000;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_TRACKED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FAILED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_SCAN_DONE = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_TRACK_EN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEAK_AGE = 1'd1;

  typedef struct packed {
    logic                active;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [STAMP_W-1:0]  stamp;
  } entry_t;

  typedef struct packed {
    logic              enable;
    logic [WORD_W-1:0] leak_age_ms;
  } cfg_t;

endpackage

// ===== rtl/core/att_cell.sv =====
// One slot of the rotating table: active mark plus handle, size and stamp.
// Depends on att_pkg for entry_t.
module att_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  att_pkg::entry_t d_in,
  output att_pkg::entry_t q
);

  logic                         active_r;
  logic [att_pkg::HANDLE_W-1:0] handle_r;
  logic [att_pkg::SIZE_W-1:0]   size_r;
  logic [att_pkg::STAMP_W-1:0]  stamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (shift_en) begin
      active_r <= d_in.active;
    end
  end

  // payload is only meaningful while active, no reset
  always_ff @(posedge clk) begin
    if (shift_en) begin
      handle_r <= d_in.handle;
      size_r   <= d_in.size;
      stamp_r  <= d_in.stamp;
    end
  end

  assign q.active = active_r;
  assign q.handle = handle_r;
  assign q.size   = size_r;
  assign q.stamp  = stamp_r;

endmodule

// ===== rtl/core/att_ctrl.sv =====
// Command sequencer: walks the cell ring once per lookup or scan, keeps the
// counters and owns the result register. Depends on att_pkg.
module att_ctrl #(
  parameter int SLOTS = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [att_pkg::CMD_W-1:0]      in_tuser,
  input  logic [att_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [att_pkg::STATUS_W-1:0]   out_tuser,
  output logic [att_pkg::OUT_DATA_W-1:0] out_tdata,
  input  att_pkg::cfg_t                  cfg,
  input  att_pkg::entry_t                head,
  output att_pkg::entry_t                wb,
  output logic                           shift_en
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_WALK, S_FIN, S_RESP} state_t;

  state_t                              state_r;
  logic [att_pkg::CMD_W-1:0]           cmd_r;
  logic [att_pkg::HANDLE_W-1:0]        handle_r;
  logic [att_pkg::SIZE_W-1:0]          size_r;
  logic [att_pkg::STAMP_W-1:0]         now_r;
  logic [att_pkg::THR_W-1:0]           thr_r;
  logic [IDX_W-1:0]                    step_r;
  logic                                found_r;
  logic [IDX_W-1:0]                    hit_idx_r;
  logic [att_pkg::SIZE_W-1:0]          hit_size_r;
  logic [CNT_W-1:0]                    leak_cnt_r;
  logic [att_pkg::WORD_W-1:0]          leak_sum_r;
  logic [att_pkg::STATUS_W-1:0]        status_r;
  logic [CNT_W-1:0]                    live_r;
  logic [att_pkg::WORD_W-1:0]          used_r;
  logic [att_pkg::WORD_W-1:0]          peak_r;
  logic [att_pkg::WORD_W-1:0]          allocs_r;
  logic [att_pkg::WORD_W-1:0]          frees_r;
  logic [att_pkg::WORD_W-1:0]          fails_r;
  logic                                out_valid_r;
  logic [att_pkg::STATUS_W-1:0]        out_status_r;
  logic [att_pkg::OUT_DATA_W-1:0]      out_data_r;

  logic [att_pkg::HANDLE_W-1:0]        in_handle;
  logic [att_pkg::SIZE_W-1:0]          in_size;
  logic                                in_ok;
  logic [att_pkg::STAMP_W-1:0]         in_now;
  logic [att_pkg::STAMP_W-1:0]         age_us;
  logic                                is_leak;
  logic                                alloc_hit;
  logic                                free_hit;
  logic                                last_step;
  logic [att_pkg::WORD_W-1:0]          used_add_nxt;
  logic [att_pkg::WORD_W-1:0]          used_sub_nxt;

  assign in_handle = in_tdata[31:0];
  assign in_size   = in_tdata[55:32];
  assign in_ok     = in_tdata[56];
  assign in_now    = in_tdata[104:57];

  // age_ms > limit  <=>  age_us >= (limit + 1) * 1000
  assign age_us    = now_r - head.stamp;
  assign is_leak   = head.active && (age_us >= att_pkg::STAMP_W'(thr_r));
  assign alloc_hit = (cmd_r == att_pkg::CMD_ALLOC) && !found_r && !head.active;
  assign free_hit  = (cmd_r == att_pkg::CMD_FREE) && !found_r && head.active &&
                     (head.handle == handle_r);
  assign last_step = (step_r == IDX_W'(SLOTS - 1));

  assign used_add_nxt = used_r + att_pkg::WORD_W'(size_r);
  assign used_sub_nxt = used_r - att_pkg::WORD_W'(hit_size_r);

  always_comb begin
    wb = head;
    if (alloc_hit) begin
      wb.active = 1'b1;
      wb.handle = handle_r;
      wb.size   = size_r;
      wb.stamp  = now_r;
    end else if (free_hit) begin
      wb.active = 1'b0;
    end
  end

  assign shift_en   = (state_r == S_WALK);
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      live_r      <= '0;
      used_r      <= '0;
      peak_r      <= '0;
      allocs_r    <= '0;
      frees_r     <= '0;
      fails_r     <= '0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r      <= in_tuser;
            handle_r   <= in_handle;
            size_r     <= in_size;
            now_r      <= in_now;
            step_r     <= '0;
            found_r    <= 1'b0;
            hit_idx_r  <= '0;
            leak_cnt_r <= '0;
            leak_sum_r <= '0;
            case (in_tuser)
              att_pkg::CMD_ALLOC: begin
                if (!cfg.enable) begin
                  status_r <= att_pkg::ST_IGNORED;
                  state_r  <= S_RESP;
                end else if (!in_ok || in_handle == '0) begin
                  fails_r  <= fails_r + 1'b1;
                  status_r <= att_pkg::ST_FAILED;
                  state_r  <= S_RESP;
                end else begin
                  state_r <= S_WALK;
                end
              end
              att_pkg::CMD_FREE: begin
                if (!cfg.enable) begin
                  status_r <= att_pkg::ST_IGNORED;
                  state_r  <= S_RESP;
                end else if (in_handle == '0) begin
                  status_r <= att_pkg::ST_UNKNOWN;
                  state_r  <= S_RESP;
                end else begin
                  state_r <= S_WALK;
                end
              end
              att_pkg::CMD_SCAN: begin
                state_r <= S_PREP;
              end
              default: begin
                status_r <= att_pkg::ST_IGNORED;
                state_r  <= S_RESP;
              end
            endcase
          end
        end
        S_PREP: begin
          thr_r   <= (att_pkg::THR_W'(cfg.leak_age_ms) + att_pkg::THR_W'(1)) *
                     att_pkg::THR_W'(att_pkg::US_PER_MS);
          state_r <= S_WALK;
        end
        S_WALK: begin
          step_r <= step_r + 1'b1;
          if (alloc_hit || free_hit) begin
            found_r    <= 1'b1;
            hit_idx_r  <= step_r;
            hit_size_r <= head.size;
          end
          if (cmd_r == att_pkg::CMD_SCAN && is_leak) begin
            leak_cnt_r <= leak_cnt_r + 1'b1;
            leak_sum_r <= leak_sum_r + att_pkg::WORD_W'(head.size);
          end
          if (last_step) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          case (cmd_r)
            att_pkg::CMD_ALLOC: begin
              if (found_r) begin
                allocs_r <= allocs_r + 1'b1;
                live_r   <= live_r + 1'b1;
                used_r   <= used_add_nxt;
                if (used_add_nxt > peak_r) begin
                  peak_r <= used_add_nxt;
                end
                status_r <= att_pkg::ST_TRACKED;
              end else begin
                status_r <= att_pkg::ST_FULL;
              end
            end
            att_pkg::CMD_FREE: begin
              if (found_r) begin
                frees_r  <= frees_r + 1'b1;
                live_r   <= live_r - 1'b1;
                used_r   <= used_sub_nxt;
                status_r <= att_pkg::ST_FREED;
              end else begin
                status_r <= att_pkg::ST_UNKNOWN;
              end
            end
            default: begin
              status_r <= att_pkg::ST_SCAN_DONE;
            end
          endcase
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_data_r   <= {1'b0, leak_sum_r, att_pkg::COUNT_W'(leak_cnt_r),
                             fails_r, frees_r, allocs_r, peak_r, used_r,
                             att_pkg::COUNT_W'(live_r), att_pkg::SLOT_W'(hit_idx_r)};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/allocation_tracking_table.sv =====
// Allocation tracking table: input/result stream channels, configuration
// port, and a ring of SLOTS att_cell entries walked by att_ctrl.
//
// Usage:
//   in_* channel: one beat per event; in_tuser = cmd, in_tdata = handle,
//   alloc_size, alloc_ok, now_us. out_* channel: one beat per event with
//   status in out_tuser and the counters in out_tdata.
//   cfg_*: register writes (0 tracking enable, 1 leak age in ms), always
//   ready, to be issued while no event is in flight.
// Sequencing:
//   Alloc and free lookups rotate the whole slot ring once through the head
//   cell, then settle the result and load it; a leak scan walks the ring too,
//   after forming the age threshold product in its own state. Events settled
//   without a lookup (disabled, failed alloc, null free, unused cmd) go
//   straight to the result load. One event is in flight at a time; the next
//   input beat is taken the cycle after the result is loaded into the output register.
// Reset: all slots are marked free, counters clear, tracking enable = 1 and
//   leak age = 30000 ms. Slot payloads are not cleared.
// Stall: a held result stays in the output register; the next event may be
//   accepted and walked meanwhile, but waits before its own result load.
module allocation_tracking_table #(
  parameter int SLOTS = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [att_pkg::CMD_W-1:0]        in_tuser,   // cmd
  // handle[31:0], alloc_size[55:32], alloc_ok[56], now_us[104:57], zero pad
  input  logic [att_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [att_pkg::STATUS_W-1:0]     out_tuser,  // status
  // slot[6:0], live_count[14:7], bytes_in_use[46:15], peak_bytes[78:47],
  // total_allocs[110:79], total_frees[142:111], alloc_failures[174:143],
  // leak_count[182:175], leak_bytes[214:183], zero pad
  output logic [att_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [att_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [att_pkg::WORD_W-1:0]       cfg_data
);

  logic                       track_en_r;
  logic [att_pkg::WORD_W-1:0] leak_age_r;
  att_pkg::cfg_t              cfg;
  att_pkg::entry_t            ring [SLOTS];
  att_pkg::entry_t            wb;
  logic                       shift_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_en_r <= 1'b1;
      leak_age_r <= att_pkg::LEAK_AGE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        att_pkg::REG_TRACK_EN: track_en_r <= cfg_data[0];
        att_pkg::REG_LEAK_AGE: leak_age_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.enable      = track_en_r;
  assign cfg.leak_age_ms = leak_age_r;

  // ring: cell k takes cell k+1, the tail takes the updated head entry
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    att_pkg::entry_t d_in;
    if (k == SLOTS - 1) begin : g_tail
      assign d_in = wb;
    end else begin : g_mid
      assign d_in = ring[k+1];
    end
    att_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d_in     (d_in),
      .q        (ring[k])
    );
  end

  att_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg        (cfg),
    .head       (ring[0]),
    .wb         (wb),
    .shift_en   (shift_en)
  );

endmodule

// ===== rtl/core/att_checker.sv =====
// Port-level checks for allocation_tracking_table, bound to the top level.
// Depends on att_pkg for field widths and status codes.
module att_props (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [att_pkg::STATUS_W-1:0]     out_tuser,
  input logic [att_pkg::OUT_DATA_W-1:0]   out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser))
    else $error("result beat changed under stall");

  // one event at a time: busy right after an input beat
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken back to back");

  // leak fields only on a scan result
  a_leak_only_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != att_pkg::ST_SCAN_DONE |-> out_tdata[214:175] == '0)
    else $error("leak fields set outside scan");

  // slot only on tracked or freed
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != att_pkg::ST_TRACKED && out_tuser != att_pkg::ST_FREED
    |-> out_tdata[6:0] == '0)
    else $error("slot set without slot update");

endmodule

bind allocation_tracking_table att_props u_att_props (.*);
